### rtl/lef_pkg.sv
// Shared widths, limits and codes of the local extrema finder.
`timescale 1ns / 1ps
`default_nettype none

package lef_pkg;

  localparam int SAMPLE_W = 24;
  localparam int POS_W    = 16;
  localparam int MAX_LEN  = 65536;

  // Highest position a sample can carry; later samples reuse it.
  localparam int POS_CAP_I = (MAX_LEN - 1 > 65535) ? 65535 : MAX_LEN - 1;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);

  // Magnitude of a difference of two samples, the product with a distance,
  // and the signed sum that holds anchor plus offset before saturation.
  localparam int MAG_W     = SAMPLE_W;
  localparam int PROD_W    = MAG_W + POS_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam logic signed [SAMPLE_W-1:0] VAL_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] VAL_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_IMAX      = 3'd0,
    KIND_IMIN      = 3'd1,
    KIND_MAX_START = 3'd2,
    KIND_MAX_END   = 3'd3,
    KIND_MIN_START = 3'd4,
    KIND_MIN_END   = 3'd5
  } point_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

### rtl/local_extrema_finder.sv
// Local extrema finder with end-point extrapolation over a streamed signal.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+----------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | sample_i, last_sample_i
//   out     | source    | out_valid_o/out_stall_i | point_kind_o, position_o,
//           |           |                       | point_value_o, last_result_o
//
// A sample that is not the last of its signal is taken whenever the input does
// not stall; a detected interior extremum leaves through the output register
// the cycle after. The last sample adds four endpoint passes. Each pass runs
// setup and emit when no extension applies, else setup, one 24x16 multiply,
// 40 steps of the restoring divider that all passes share, add/saturate, emit.
// Reset clears the window, the extremum lists and the output valid.
// A stalled output holds its word; the input stalls whenever the output
// register is full and stalled, and during the endpoint passes.
`timescale 1ns / 1ps
`default_nettype none

module local_extrema_finder
  import lef_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 point_kind_o,
  output logic [POS_W-1:0]           position_o,
  output logic signed [SAMPLE_W-1:0] point_value_o,
  output logic                       last_result_o
);

  localparam logic [1:0]           EP_LAST  = 2'd3;
  localparam logic [1:0]           FILL_ONE = 2'd1;
  localparam logic [1:0]           FILL_TWO = 2'd2;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

  // ---------------------------------------------------------------------
  // Stream state: three-sample window and the extremum bookkeeping.
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] older_q, middle_q, bstart_q;
  logic [POS_W-1:0]           middle_pos_q, sample_index_q;
  logic [1:0]                 fill_q, max_cnt_q, min_cnt_q;
  logic [POS_W-1:0]           fmax_pos_q [2];
  logic [POS_W-1:0]           rmax_pos_q [2];
  logic [POS_W-1:0]           fmin_pos_q [2];
  logic [POS_W-1:0]           rmin_pos_q [2];
  logic signed [SAMPLE_W-1:0] fmax_val_q [2];
  logic signed [SAMPLE_W-1:0] rmax_val_q [2];
  logic signed [SAMPLE_W-1:0] fmin_val_q [2];
  logic signed [SAMPLE_W-1:0] rmin_val_q [2];

  // Sequencer.
  state_e     state_q, state_d;
  logic [1:0] ep_q, ep_d;

  // Operands and results of the shared extrapolation unit.
  logic [MAG_W-1:0]           ud_q;
  logic [POS_W-1:0]           up_q, den_q, rem_q;
  logic                       neg_q;
  logic signed [SAMPLE_W-1:0] vk_q, bnd_q, res_q;
  logic [PROD_W-1:0]          quo_q;
  logic [DIV_CNT_W-1:0]       div_cnt_q;

  // Output register.
  logic                       out_valid_q;
  point_kind_e                out_kind_q;
  logic [POS_W-1:0]           out_pos_q;
  logic signed [SAMPLE_W-1:0] out_val_q;
  logic                       out_last_q;

  logic out_free, accept, is_max_pt, is_min_pt, int_load, ep_load, stream_clear;

  // The output register can take a word when empty or being drained now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Interior extremum: the middle sample strictly beats both neighbors.
  assign is_max_pt = (fill_q == FILL_TWO) && (middle_q > older_q) && (middle_q > sample_i);
  assign is_min_pt = (fill_q == FILL_TWO) && (middle_q < older_q) && (middle_q < sample_i);

  assign int_load     = accept && (is_max_pt || is_min_pt);
  assign ep_load      = (state_q == ST_EMIT) && out_free;
  assign stream_clear = ep_load && (ep_q == EP_LAST);

  // ---------------------------------------------------------------------
  // Window and extremum lists. A finished signal drops everything.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q        <= '0;
      middle_q       <= '0;
      bstart_q       <= '0;
      middle_pos_q   <= '0;
      sample_index_q <= '0;
      fill_q         <= '0;
      max_cnt_q      <= '0;
      min_cnt_q      <= '0;
      for (int i = 0; i < 2; i++) begin
        fmax_pos_q[i] <= '0;
        rmax_pos_q[i] <= '0;
        fmin_pos_q[i] <= '0;
        rmin_pos_q[i] <= '0;
        fmax_val_q[i] <= '0;
        rmax_val_q[i] <= '0;
        fmin_val_q[i] <= '0;
        rmin_val_q[i] <= '0;
      end
    end else if (stream_clear) begin
      older_q        <= '0;
      middle_q       <= '0;
      bstart_q       <= '0;
      middle_pos_q   <= '0;
      sample_index_q <= '0;
      fill_q         <= '0;
      max_cnt_q      <= '0;
      min_cnt_q      <= '0;
      for (int i = 0; i < 2; i++) begin
        fmax_pos_q[i] <= '0;
        rmax_pos_q[i] <= '0;
        fmin_pos_q[i] <= '0;
        rmin_pos_q[i] <= '0;
        fmax_val_q[i] <= '0;
        rmax_val_q[i] <= '0;
        fmin_val_q[i] <= '0;
        rmin_val_q[i] <= '0;
      end
    end else if (accept) begin
      if (fill_q == '0) begin
        bstart_q <= sample_i;
      end
      if (is_max_pt) begin
        // Keep the first two maxima, shift the newest into the recent pair.
        if (!max_cnt_q[1]) begin
          fmax_pos_q[max_cnt_q[0]] <= middle_pos_q;
          fmax_val_q[max_cnt_q[0]] <= middle_q;
          max_cnt_q                <= max_cnt_q + FILL_ONE;
        end
        rmax_pos_q[0] <= rmax_pos_q[1];
        rmax_val_q[0] <= rmax_val_q[1];
        rmax_pos_q[1] <= middle_pos_q;
        rmax_val_q[1] <= middle_q;
      end
      if (is_min_pt) begin
        if (!min_cnt_q[1]) begin
          fmin_pos_q[min_cnt_q[0]] <= middle_pos_q;
          fmin_val_q[min_cnt_q[0]] <= middle_q;
          min_cnt_q                <= min_cnt_q + FILL_ONE;
        end
        rmin_pos_q[0] <= rmin_pos_q[1];
        rmin_val_q[0] <= rmin_val_q[1];
        rmin_pos_q[1] <= middle_pos_q;
        rmin_val_q[1] <= middle_q;
      end
      older_q      <= middle_q;
      middle_q     <= sample_i;
      middle_pos_q <= sample_index_q;
      if (fill_q != FILL_TWO) begin
        fill_q <= fill_q + FILL_ONE;
      end
      // Positions stick at the cap on an overlong signal.
      if (sample_index_q < POS_CAP) begin
        sample_index_q <= sample_index_q + POS_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Operand selection for endpoint ep_q: bit 1 picks minima, bit 0 the end.
  // Start: line through the first two, anchored at the first, to position 0.
  // End: line through the last two, anchored at the newest, to the last sample.
  // ---------------------------------------------------------------------
  logic                       is_end, is_minep, sel_ok, diff_neg;
  logic signed [SAMPLE_W-1:0] va, vb, sel_bnd;
  logic [POS_W-1:0]           pa, pb;
  logic [1:0]                 sel_cnt;
  logic signed [SAMPLE_W:0]   diff, diff_abs;

  assign is_end   = ep_q[0];
  assign is_minep = ep_q[1];

  always_comb begin
    unique case (ep_q)
      2'd0: begin
        va = fmax_val_q[0]; pa = fmax_pos_q[0];
        vb = fmax_val_q[1]; pb = fmax_pos_q[1];
        sel_cnt = max_cnt_q;
      end
      2'd1: begin
        va = rmax_val_q[0]; pa = rmax_pos_q[0];
        vb = rmax_val_q[1]; pb = rmax_pos_q[1];
        sel_cnt = max_cnt_q;
      end
      2'd2: begin
        va = fmin_val_q[0]; pa = fmin_pos_q[0];
        vb = fmin_val_q[1]; pb = fmin_pos_q[1];
        sel_cnt = min_cnt_q;
      end
      default: begin
        va = rmin_val_q[0]; pa = rmin_pos_q[0];
        vb = rmin_val_q[1]; pb = rmin_pos_q[1];
        sel_cnt = min_cnt_q;
      end
    endcase
  end

  assign diff     = $signed({vb[SAMPLE_W-1], vb}) - $signed({va[SAMPLE_W-1], va});
  assign diff_neg = diff[SAMPLE_W];
  assign diff_abs = diff_neg ? -diff : diff;
  // Extension needs two extrema at distinct positions.
  assign sel_ok   = sel_cnt[1] && (pb > pa);
  assign sel_bnd  = is_end ? middle_q : bstart_q;

  // ---------------------------------------------------------------------
  // Add the signed offset to the anchor, saturate, keep the outer value.
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0]    vk_ext, qm_ext, sum;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic                       outer;

  assign vk_ext = $signed({{(SUM_W-SAMPLE_W){vk_q[SAMPLE_W-1]}}, vk_q});
  assign qm_ext = $signed({2'b00, quo_q});
  assign sum    = neg_q ? (vk_ext - qm_ext) : (vk_ext + qm_ext);

  always_comb begin
    priority if (sum > $signed({{(SUM_W-SAMPLE_W){1'b0}}, VAL_HI})) begin
      sat_val = VAL_HI;
    end else if (sum < $signed({{(SUM_W-SAMPLE_W){1'b1}}, VAL_LO})) begin
      sat_val = VAL_LO;
    end else begin
      sat_val = sum[SAMPLE_W-1:0];
    end
  end

  assign outer = is_minep ? (sat_val < bnd_q) : (sat_val > bnd_q);

  // Restoring divider step: one quotient bit a cycle.
  logic [POS_W:0] rem_sh;
  logic           rem_ge;

  assign rem_sh = {rem_q, quo_q[PROD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_SETUP: begin
        ud_q  <= diff_abs[MAG_W-1:0];
        // Start looks back to position 0, end looks forward to the last sample.
        up_q  <= is_end ? (middle_pos_q - pb) : pa;
        den_q <= pb - pa;
        neg_q <= is_end ? diff_neg : !diff_neg;
        vk_q  <= is_end ? vb : va;
        bnd_q <= sel_bnd;
        res_q <= sel_bnd;
      end
      ST_MUL: begin
        quo_q     <= PROD_W'(ud_q) * PROD_W'(up_q);
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q     <= rem_ge ? rem_sh[POS_W-1:0] - den_q : rem_sh[POS_W-1:0];
        quo_q     <= {quo_q[PROD_W-2:0], rem_ge};
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      ST_ADD: begin
        if (outer) begin
          res_q <= sat_val;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ep_q    <= '0;
    end else begin
      state_q <= state_d;
      ep_q    <= ep_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ep_d    = ep_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_sample_i) begin
          state_d = ST_SETUP;
          ep_d    = '0;
        end
      end
      ST_SETUP: begin
        state_d = sel_ok ? ST_MUL : ST_EMIT;
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == DIV_LAST) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (ep_q == EP_LAST) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SETUP;
            ep_d    = ep_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  point_kind_e ep_kind;

  always_comb begin
    unique case (ep_q)
      2'd0:    ep_kind = KIND_MAX_START;
      2'd1:    ep_kind = KIND_MAX_END;
      2'd2:    ep_kind = KIND_MIN_START;
      default: ep_kind = KIND_MIN_END;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (int_load || ep_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (int_load) begin
      out_kind_q <= is_max_pt ? KIND_IMAX : KIND_IMIN;
      out_pos_q  <= middle_pos_q;
      out_val_q  <= middle_q;
      out_last_q <= 1'b0;
    end else if (ep_load) begin
      out_kind_q <= ep_kind;
      out_pos_q  <= is_end ? middle_pos_q : '0;
      out_val_q  <= res_q;
      out_last_q <= (ep_q == EP_LAST);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_kind_o  = out_kind_q;
  assign position_o    = out_pos_q;
  assign point_value_o = out_val_q;
  assign last_result_o = out_last_q;

endmodule

`default_nettype wire

### rtl/lef_checker.sv
// Port-level checks of the local extrema finder and their bind.
`timescale 1ns / 1ps
`default_nettype none

module lef_checker
  import lef_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [2:0]       point_kind_o,
  input logic [POS_W-1:0] position_o,
  input logic             last_result_o
);

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // Flag the end of a signal only on the minima end point.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o |-> point_kind_o == KIND_MIN_END)
    else $error("last flag on a word that is not the minima end point");

  // Emit no unused kind code.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> point_kind_o <= 3'(KIND_MIN_END))
    else $error("unused point kind emitted");

  // Place start points at position zero.
  a_start_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (point_kind_o == KIND_MAX_START || point_kind_o == KIND_MIN_START)
    |-> position_o == '0)
    else $error("start point away from position zero");

endmodule

bind local_extrema_finder lef_checker u_lef_checker (.*);

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the local extrema finder: streamed signals, predicted points.
`timescale 1ns / 1ps

module tb;
  import lef_pkg::*;

  // Sample range as plain integers, and the cap on the extension offset
  // (anything this far out saturates anyway).
  localparam longint VAL_HI_L    = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint VAL_LO_L    = -VAL_HI_L - 1;
  localparam longint unsigned OFFSET_CEIL = 64'd1 << (SAMPLE_W + 2);

  localparam int RANDOM_ITEMS = 160;
  localparam int IDLE_PCT     = 27;
  localparam int CALM_FROM    = 400;     // window of cycles with no idling on either side
  localparam int CALM_TO      = 1400;
  localparam int HOLD_CYCLES  = 120;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 250;     // four endpoint passes at worst, with margin
  localparam int TIMEOUT_NS   = 4_000_000;

  typedef enum int {
    STYLE_NOISE,
    STYLE_WAVE,
    STYLE_FLAT,
    STYLE_RAILS
  } wave_style_e;

  typedef struct {
    logic signed [SAMPLE_W-1:0] val;
    logic                       fin;
  } sample_word_t;

  typedef struct {
    point_kind_e                kind;
    logic [POS_W-1:0]           pos;
    logic signed [SAMPLE_W-1:0] val;
    logic                       last;
  } point_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Stimulus side
  logic                       in_valid    = 1'b0;
  logic signed [SAMPLE_W-1:0] sample      = '0;
  logic                       last_sample = 1'b0;
  logic                       in_stall;

  // Result side
  logic                       out_stall = 1'b0;
  logic                       out_valid;
  logic [2:0]                 point_kind;
  logic [POS_W-1:0]           position;
  logic signed [SAMPLE_W-1:0] point_value;
  logic                       last_result;

  sample_word_t sample_feed[$];      // words waiting to be offered
  point_t       pending_points[$];   // points predicted, not yet seen
  sample_word_t next_word;
  point_t       want_point;

  int unsigned cycle_no    = 0;
  int unsigned points_seen = 0;
  int unsigned hold_left   = 0;
  int unsigned holds_done  = 0;
  int unsigned fails       = 0;

  // Predictor state: three-sample window, boundary start value, and per kind
  // (0 maxima, 1 minima) the first two and the two most recent extrema.
  logic signed [SAMPLE_W-1:0] win_old, win_mid, start_val;
  logic [POS_W-1:0]           next_pos, mid_pos;
  int unsigned                fill_cnt;
  int unsigned                ext_cnt [2];
  logic [POS_W-1:0]           first_p [2][2];
  logic signed [SAMPLE_W-1:0] first_v [2][2];
  logic [POS_W-1:0]           recent_p[2][2];
  logic signed [SAMPLE_W-1:0] recent_v[2][2];

  local_extrema_finder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_i      (sample),
    .last_sample_i (last_sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .point_kind_o  (point_kind),
    .position_o    (position),
    .point_value_o (point_value),
    .last_result_o (last_result)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
  end

  function automatic longint rail_clip(input longint v);
    if (v > VAL_HI_L) return VAL_HI_L;
    if (v < VAL_LO_L) return VAL_LO_L;
    return v;
  endfunction

  // Both sides idle in about a quarter of the cycles, except in the calm window.
  function automatic bit take_break();
    return (cycle_no < CALM_FROM || cycle_no >= CALM_TO) &&
           ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Value at pt of the line through (pa,va),(pb,vb), anchored at (pk,vk).
  // Integer divide truncates toward zero; a huge offset is clamped before
  // the final saturation so nothing overflows.
  function automatic longint extend_line(input longint va, pa, vb, pb, vk, pk, pt);
    longint diff, dp;
    longint unsigned den, ud, up, whole, rem, offset;
    diff = vb - va;
    dp   = pt - pk;
    den  = pb - pa;
    ud   = (diff < 0) ? -diff : diff;
    up   = (dp < 0) ? -dp : dp;
    whole = ud / den;
    rem   = ud % den;
    if (up != 0 && whole > OFFSET_CEIL / up) offset = OFFSET_CEIL;
    else offset = whole * up + (rem * up) / den;
    return rail_clip(((diff < 0) != (dp < 0)) ? vk - longint'(offset) : vk + longint'(offset));
  endfunction

  function automatic void push_point(input point_kind_e kind, input logic [POS_W-1:0] pos,
                                     input longint val, input logic last);
    point_t pt;
    pt.kind = kind;
    pt.pos  = pos;
    pt.val  = val[SAMPLE_W-1:0];
    pt.last = last;
    pending_points.push_back(pt);
  endfunction

  function automatic void clear_stream();
    win_old   = '0;
    win_mid   = '0;
    start_val = '0;
    next_pos  = '0;
    mid_pos   = '0;
    fill_cnt  = 0;
    for (int k = 0; k < 2; k++) begin
      ext_cnt[k] = 0;
      for (int j = 0; j < 2; j++) begin
        first_p[k][j]  = '0;
        first_v[k][j]  = '0;
        recent_p[k][j] = '0;
        recent_v[k][j] = '0;
      end
    end
  endfunction

  // Log the middle sample as an extremum of kind k and predict its point.
  function automatic void note_extremum(input int k);
    if (ext_cnt[k] < 2) begin
      first_p[k][ext_cnt[k]] = mid_pos;
      first_v[k][ext_cnt[k]] = win_mid;
      ext_cnt[k]++;
    end
    recent_p[k][0] = recent_p[k][1];
    recent_v[k][0] = recent_v[k][1];
    recent_p[k][1] = mid_pos;
    recent_v[k][1] = win_mid;
    push_point((k == 0) ? KIND_IMAX : KIND_IMIN, mid_pos, win_mid, 1'b0);
  endfunction

  // Advance the predictor by one accepted sample word.
  function automatic void track_sample(input logic signed [SAMPLE_W-1:0] x, input logic fin);
    longint           start_pt[2], end_pt[2];
    longint           t;
    logic [POS_W-1:0] p;
    p = next_pos;
    if (fill_cnt == 0) start_val = x;
    if (fill_cnt >= 2) begin
      if (win_mid > win_old && win_mid > x) note_extremum(0);
      else if (win_mid < win_old && win_mid < x) note_extremum(1);
    end
    win_old = win_mid;
    win_mid = x;
    mid_pos = p;
    if (fill_cnt < 2) fill_cnt++;
    if (p < POS_CAP) next_pos = p + 1'b1;
    if (fin) begin
      for (int k = 0; k < 2; k++) begin
        start_pt[k] = start_val;
        end_pt[k]   = x;
        if (ext_cnt[k] >= 2) begin
          // Extend only when the line lies further out than the boundary sample;
          // extrema sharing one position (after the cap) give no line at all.
          if (first_p[k][1] > first_p[k][0]) begin
            t = extend_line(first_v[k][0], first_p[k][0], first_v[k][1], first_p[k][1],
                            first_v[k][0], first_p[k][0], 0);
            if ((k == 0) ? (t > start_pt[k]) : (t < start_pt[k])) start_pt[k] = t;
          end
          if (recent_p[k][1] > recent_p[k][0]) begin
            t = extend_line(recent_v[k][0], recent_p[k][0], recent_v[k][1], recent_p[k][1],
                            recent_v[k][1], recent_p[k][1], p);
            if ((k == 0) ? (t > end_pt[k]) : (t < end_pt[k])) end_pt[k] = t;
          end
        end
      end
      push_point(KIND_MAX_START, '0, start_pt[0], 1'b0);
      push_point(KIND_MAX_END,   p,  end_pt[0],   1'b0);
      push_point(KIND_MIN_START, '0, start_pt[1], 1'b0);
      push_point(KIND_MIN_END,   p,  end_pt[1],   1'b1);
      clear_stream();
    end
  endfunction

  function automatic void feed(input longint v, input logic fin);
    sample_word_t w;
    w.val = SAMPLE_W'(rail_clip(v));
    w.fin = fin;
    sample_feed.push_back(w);
  endfunction

  // One signal of len samples in the given style; the last one carries the flag.
  task automatic add_signal(input int len, input wave_style_e style);
    longint                     base, trend, amp, v;
    int                         half;
    logic signed [SAMPLE_W-1:0] raw;
    base  = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
    trend = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
    if ($urandom_range(1) == 1) trend = -trend;
    amp   = longint'($urandom_range(0, 1 << $urandom_range(0, 22)));
    half  = $urandom_range(1, 3);
    for (int i = 0; i < len; i++) begin
      case (style)
        STYLE_NOISE: begin
          raw = SAMPLE_W'($urandom);
          v   = raw;
        end
        STYLE_WAVE: begin
          v = base + trend * i + (((i / half) % 2 == 1) ? amp : -amp) + $urandom_range(0, 3);
        end
        STYLE_FLAT: begin
          v = $urandom_range(0, 2);
        end
        default: begin
          v = ($urandom_range(1) == 1) ? VAL_HI_L - $urandom_range(0, 7)
                                       : VAL_LO_L + $urandom_range(0, 7);
        end
      endcase
      feed(v, i == len - 1);
    end
  endtask

  // Driver: predict on every accepted word, then offer the next one only when
  // the channel is free, so a stalled word holds.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_sample(sample, last_sample);
      if (!in_valid || !in_stall) begin
        if (sample_feed.size() != 0 && !take_break()) begin
          next_word = sample_feed.pop_front();
          in_valid    <= 1'b1;
          sample      <= next_word.val;
          last_sample <= next_word.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-offs: twice, after 12 and after 150 points have come, the receiver stalls
  // for a long stretch while the driver keeps offering, so the block backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && points_seen >= 12) ||
                 (holds_done == 1 && points_seen >= 150)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: check every accepted point against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        points_seen <= points_seen + 1;
        if (pending_points.size() == 0) begin
          $error("unexpected point: kind %0d position %0d value %0d",
                 point_kind, position, point_value);
          fails++;
        end else begin
          want_point = pending_points.pop_front();
          if (point_kind !== want_point.kind) begin
            $error("point_kind: expected %0d, got %0d", want_point.kind, point_kind);
            fails++;
          end
          if (position !== want_point.pos) begin
            $error("position: expected %0d, got %0d", want_point.pos, position);
            fails++;
          end
          if (point_value !== want_point.val) begin
            $error("point_value: expected %0d, got %0d", want_point.val, point_value);
            fails++;
          end
          if (last_result !== want_point.last) begin
            $error("last_result: expected %0d, got %0d", want_point.last, last_result);
            fails++;
          end
        end
      end
      out_stall <= (hold_left != 0) || take_break();
    end
  end

  initial begin
    int total;
    int len;
    int pick;
    wave_style_e style;
    clear_stream();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One-sample signals at both rails: all four endpoints sit at position 0.
    feed(VAL_HI_L, 1'b1);
    feed(VAL_LO_L, 1'b1);
    // Two samples: no interior point, boundaries only.
    feed(5, 1'b0); feed(-3, 1'b1);
    // Plateau: equal neighbours give no extremum.
    feed(0, 1'b0); feed(7, 1'b0); feed(7, 1'b0); feed(0, 1'b1);
    // Rail-to-rail swings: both extensions of the maxima saturate.
    feed(VAL_LO_L, 1'b0); feed(VAL_HI_L, 1'b0); feed(VAL_LO_L, 1'b0); feed(0, 1'b0);
    feed(VAL_LO_L, 1'b0); feed(VAL_HI_L, 1'b0); feed(VAL_LO_L, 1'b1);
    // Rising maxima and falling minima: extensions replace all four boundaries.
    feed(10, 1'b0); feed(20, 1'b0); feed(0, 1'b0); feed(30, 1'b0);
    feed(-7, 1'b0); feed(41, 1'b0); feed(5, 1'b1);

    // Random signals, mostly short, of mixed shapes.
    total = 0;
    while (total < RANDOM_ITEMS) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
      pick = $urandom_range(99);
      if (pick < 20) style = STYLE_NOISE;
      else if (pick < 70) style = STYLE_WAVE;
      else if (pick < 85) style = STYLE_FLAT;
      else style = STYLE_RAILS;
      add_signal(len, style);
      total += len;
    end

    while (sample_feed.size() != 0 || in_valid) @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
